// ----- rtl/bptc_pkg.sv -----
// Shared types, constants and an arithmetic helper for the barometer compensation block.
// No dependencies; the RTL modules refer to this package by scoped names.
package bptc_pkg;

  localparam int unsigned CalNum = 6;
  localparam int unsigned AddrW  = 5;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_T1_T2 = 3'd0;
  localparam logic [2:0] REG_T3_P1 = 3'd1;
  localparam logic [2:0] REG_P2_P3 = 3'd2;
  localparam logic [2:0] REG_P4_P5 = 3'd3;
  localparam logic [2:0] REG_P6_P7 = 3'd4;
  localparam logic [2:0] REG_P8_P9 = 3'd5;

  localparam logic signed [32:0] TFineOffset = 33'sd128000;
  localparam logic [20:0]        PressFull   = 21'd1048576;
  localparam logic [16:0]        DivScale    = 17'd3125;
  localparam logic [31:0]        TempRound   = 32'd128;
  localparam logic [63:0]        DenBias     = 64'h0000_8000_0000_0000;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } cal_t;

  // Beat handed from one divider cell to the next.
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] num;
    logic [63:0] den;
    logic        neg;
    logic        inval;
    logic [31:0] temp;
  } div_t;

  // Product modulo 2^64 of a 64-bit word and a 17-bit signed factor, as two
  // 32-bit partial products.
  function automatic logic [63:0] mul64x17(input logic [63:0] x, input logic [16:0] p);
    logic signed [49:0] lo;
    logic        [31:0] pe;
    logic        [31:0] hi;
    lo = $signed({1'b0, x[31:0]}) * $signed(p);
    pe = {{15{p[16]}}, p};
    hi = x[63:32] * pe;
    return {{14{lo[49]}}, lo} + {hi, 32'd0};
  endfunction

endpackage

// ----- rtl/bptc_if.sv -----
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on nothing; used by the top level.
interface bptc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temp;
  logic [19:0] raw_press;
  modport source (output valid, raw_temp, raw_press, input ready);
  modport sink (input valid, raw_temp, raw_press, output ready);
endinterface

interface bptc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temp_centi;
  logic        [31:0] press_q24_8;
  logic               press_invalid;
  modport source (output valid, temp_centi, press_q24_8, press_invalid, input ready);
  modport sink (input valid, temp_centi, press_q24_8, press_invalid, output ready);
endinterface

// ----- rtl/baro_temp_pressure_compensation_top.sv -----
// Barometer temperature and pressure compensation, top level.
// Pipeline: 9 front stages, 64 divider cells (one quotient bit each), 5 back stages.
// Throughput one sample pair per cycle when not stalled; every stage holds its beat
// under back-pressure and bubbles close up, so input is taken while a stage is free.
// Reset clears all pipeline valid flags and the six calibration registers to zero.
// Depends on bptc_pkg, bptc_if, bptc_pre, bptc_div_cell and bptc_post.
module baro_temp_pressure_compensation_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bptc_pkg::AddrW-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  bptc_in_if.sink                        in_i,
  bptc_out_if.source                     out_o
);

  localparam int Cells = 64;

  logic [31:0] cal_q [bptc_pkg::CalNum];
  logic [2:0]  reg_idx;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bptc_pkg::CalNum; i++) begin
        cal_q[i] <= '0;
      end
    end else if (wr_en) begin
      case (reg_idx)
        bptc_pkg::REG_T1_T2: cal_q[0] <= pwdata;
        bptc_pkg::REG_T3_P1: cal_q[1] <= pwdata;
        bptc_pkg::REG_P2_P3: cal_q[2] <= pwdata;
        bptc_pkg::REG_P4_P5: cal_q[3] <= pwdata;
        bptc_pkg::REG_P6_P7: cal_q[4] <= pwdata;
        bptc_pkg::REG_P8_P9: cal_q[5] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bptc_pkg::REG_T1_T2: prdata = cal_q[0];
      bptc_pkg::REG_T3_P1: prdata = cal_q[1];
      bptc_pkg::REG_P2_P3: prdata = cal_q[2];
      bptc_pkg::REG_P4_P5: prdata = cal_q[3];
      bptc_pkg::REG_P6_P7: prdata = cal_q[4];
      bptc_pkg::REG_P8_P9: prdata = cal_q[5];
      default:             prdata = '0;
    endcase
  end

  bptc_pkg::cal_t cal;

  always_comb begin
    cal.t1 = cal_q[0][15:0];
    cal.t2 = cal_q[0][31:16];
    cal.t3 = cal_q[1][15:0];
    cal.p1 = cal_q[1][31:16];
    cal.p2 = cal_q[2][15:0];
    cal.p3 = cal_q[2][31:16];
    cal.p4 = cal_q[3][15:0];
    cal.p5 = cal_q[3][31:16];
    cal.p6 = cal_q[4][15:0];
    cal.p7 = cal_q[4][31:16];
    cal.p8 = cal_q[5][15:0];
    cal.p9 = cal_q[5][31:16];
  end

  logic           chain_vld [Cells+1];
  logic           chain_rdy [Cells+1];
  bptc_pkg::div_t chain_dat [Cells+1];

  bptc_pre u_pre (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cal_i       (cal),
    .valid_i     (in_i.valid),
    .ready_o     (in_i.ready),
    .raw_temp_i  (in_i.raw_temp),
    .raw_press_i (in_i.raw_press),
    .valid_o     (chain_vld[0]),
    .ready_i     (chain_rdy[0]),
    .data_o      (chain_dat[0])
  );

  for (genvar g = 0; g < Cells; g++) begin : g_cell
    bptc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_vld[g]),
      .ready_o (chain_rdy[g]),
      .data_i  (chain_dat[g]),
      .valid_o (chain_vld[g+1]),
      .ready_i (chain_rdy[g+1]),
      .data_o  (chain_dat[g+1])
    );
  end

  bptc_post u_post (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cal_i           (cal),
    .valid_i         (chain_vld[Cells]),
    .ready_o         (chain_rdy[Cells]),
    .data_i          (chain_dat[Cells]),
    .valid_o         (out_o.valid),
    .ready_i         (out_o.ready),
    .temp_centi_o    (out_o.temp_centi),
    .press_q24_8_o   (out_o.press_q24_8),
    .press_invalid_o (out_o.press_invalid)
  );

endmodule

// ----- rtl/bptc_pre.sv -----
// Front pipeline: temperature compensation and the pressure numerator and divisor.
// Depends on bptc_pkg; feeds the first divider cell.
module bptc_pre (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bptc_pkg::cal_t     cal_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [19:0]        raw_temp_i,
  input  logic [19:0]        raw_press_i,
  output logic               valid_o,
  input  logic               ready_i,
  output bptc_pkg::div_t     data_o
);

  localparam int Stages = 9;

  logic [Stages-1:0] vld_q;
  logic [Stages-1:0] rdy;

  always_comb begin
    rdy[Stages-1] = !vld_q[Stages-1] || ready_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[Stages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= valid_i;
      end
      for (int k = 1; k < Stages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage A: first temperature products.
  logic signed [17:0] a_val;
  logic signed [16:0] b_val;
  logic signed [33:0] a_prod;
  logic signed [33:0] b_sq;
  logic [31:0] ta_q, bs_q;
  logic [19:0] rp_a_q;

  assign a_val  = $signed({1'b0, raw_temp_i[19:3]}) - $signed({1'b0, cal_i.t1, 1'b0});
  assign b_val  = $signed({1'b0, raw_temp_i[19:4]}) - $signed({1'b0, cal_i.t1});
  assign a_prod = a_val * cal_i.t2;
  assign b_sq   = b_val * b_val;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      ta_q   <= a_prod[31:0];
      bs_q   <= b_sq[31:0];
      rp_a_q <= raw_press_i;
    end
  end

  // Stage B.
  logic signed [31:0] bs_sh;
  logic signed [47:0] m3;
  logic [31:0] tv1_q, m3_q;
  logic [19:0] rp_b_q;

  assign bs_sh = $signed(bs_q) >>> 12;
  assign m3    = bs_sh * cal_i.t3;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      tv1_q  <= 32'($signed(ta_q) >>> 11);
      m3_q   <= m3[31:0];
      rp_b_q <= rp_a_q;
    end
  end

  // Stage C: fine temperature.
  logic [31:0] tfine_q;
  logic [19:0] rp_c_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      tfine_q <= tv1_q + 32'($signed(m3_q) >>> 14);
      rp_c_q  <= rp_b_q;
    end
  end

  // Stage D: temperature result and the pressure offset term.
  logic [31:0] t5;
  logic signed [32:0] v1;
  logic [31:0] temp_d_q;
  logic signed [32:0] v1_q;
  logic [19:0] rp_d_q;

  assign t5 = {tfine_q[29:0], 2'b00} + tfine_q + bptc_pkg::TempRound;
  assign v1 = $signed({tfine_q[31], tfine_q}) - bptc_pkg::TFineOffset;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      temp_d_q <= 32'($signed(t5) >>> 8);
      v1_q     <= v1;
      rp_d_q   <= rp_c_q;
    end
  end

  // Stage E: square and linear products of the offset.
  logic signed [65:0] sq;
  logic signed [48:0] m5, m2;
  logic [63:0] sq_q;
  logic signed [48:0] m5_q, m2_q;
  logic [31:0] temp_e_q;
  logic [19:0] rp_e_q;

  assign sq = v1_q * v1_q;
  assign m5 = v1_q * cal_i.p5;
  assign m2 = v1_q * cal_i.p2;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      sq_q     <= sq[63:0];
      m5_q     <= m5;
      m2_q     <= m2;
      temp_e_q <= temp_d_q;
      rp_e_q   <= rp_d_q;
    end
  end

  // Stage F: square times P6 and P3.
  logic [63:0] sq6_q, sq3_q;
  logic signed [48:0] m5_f_q, m2_f_q;
  logic [31:0] temp_f_q;
  logic [19:0] rp_f_q;

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      sq6_q    <= bptc_pkg::mul64x17(sq_q, {cal_i.p6[15], cal_i.p6});
      sq3_q    <= bptc_pkg::mul64x17(sq_q, {cal_i.p3[15], cal_i.p3});
      m5_f_q   <= m5_q;
      m2_f_q   <= m2_q;
      temp_f_q <= temp_e_q;
      rp_f_q   <= rp_e_q;
    end
  end

  // Stage G: sum the partial terms.
  logic [63:0] m5x, m2x, p4x, v1b;
  logic [63:0] v2_q, w_q;
  logic [31:0] temp_g_q;
  logic [19:0] rp_g_q;

  assign m5x = {{15{m5_f_q[48]}}, m5_f_q};
  assign m2x = {{15{m2_f_q[48]}}, m2_f_q};
  assign p4x = {{48{cal_i.p4[15]}}, cal_i.p4};
  assign v1b = 64'($signed(sq3_q) >>> 8) + (m2x << 12);

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      v2_q     <= sq6_q + (m5x << 17) + (p4x << 35);
      w_q      <= v1b + bptc_pkg::DenBias;
      temp_g_q <= temp_f_q;
      rp_g_q   <= rp_f_q;
    end
  end

  // Stage H: divisor product and numerator base.
  logic [20:0] pn;
  logic [63:0] dprod_q, n0_q;
  logic [31:0] temp_h_q;

  assign pn = bptc_pkg::PressFull - {1'b0, rp_g_q};

  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      dprod_q  <= bptc_pkg::mul64x17(w_q, {1'b0, cal_i.p1});
      n0_q     <= {11'd0, pn, 32'd0} >> 1;
      temp_h_q <= temp_g_q;
    end
  end

  // v2 must line up with stage H, so it is carried one more stage.
  logic [63:0] v2_q_h_q;
  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      v2_q_h_q <= v2_q;
    end
  end

  logic [63:0] n0_diff;
  assign n0_diff = n0_q - v2_q_h_q;

  // Stage I: scaled numerator and shifted divisor.
  logic [63:0] den_q, num_q;
  logic [31:0] temp_i_q;

  always_ff @(posedge clk_i) begin
    if (rdy[8]) begin
      den_q    <= 64'($signed(dprod_q) >>> 33);
      num_q    <= bptc_pkg::mul64x17(n0_diff, bptc_pkg::DivScale);
      temp_i_q <= temp_h_q;
    end
  end

  // Magnitudes and quotient sign for the unsigned divider.
  always_comb begin
    data_o.rem   = '0;
    data_o.num   = num_q[63] ? (64'd0 - num_q) : num_q;
    data_o.den   = den_q[63] ? (64'd0 - den_q) : den_q;
    data_o.neg   = num_q[63] ^ den_q[63];
    data_o.inval = (den_q == 64'd0);
    data_o.temp  = temp_i_q;
  end

endmodule

// ----- rtl/bptc_div_cell.sv -----
// One restoring division cell: resolves one quotient bit per beat.
// Depends on bptc_pkg; chained 64 deep in the top level.
module bptc_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  bptc_pkg::div_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output bptc_pkg::div_t data_o
);

  logic           vld_q;
  bptc_pkg::div_t data_q;
  bptc_pkg::div_t data_d;
  logic [64:0]    trial;
  logic [64:0]    diff;
  logic           ge;

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  always_comb begin
    trial       = {data_i.rem, data_i.num[63]};
    diff        = trial - {1'b0, data_i.den};
    ge          = (trial >= {1'b0, data_i.den});
    data_d      = data_i;
    data_d.rem  = ge ? diff[63:0] : trial[63:0];
    data_d.num  = {data_i.num[62:0], ge};
  end

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

// ----- rtl/bptc_post.sv -----
// Back pipeline: signed quotient, second-order pressure correction and output register.
// Depends on bptc_pkg; fed by the last divider cell.
module bptc_post (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bptc_pkg::cal_t     cal_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  bptc_pkg::div_t     data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic signed [31:0] temp_centi_o,
  output logic        [31:0] press_q24_8_o,
  output logic               press_invalid_o
);

  localparam int Stages = 5;

  logic [Stages-1:0] vld_q;
  logic [Stages-1:0] rdy;

  always_comb begin
    rdy[Stages-1] = !vld_q[Stages-1] || ready_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[Stages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= valid_i;
      end
      for (int k = 1; k < Stages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage 0: restore the quotient sign.
  logic [63:0] p0_q;
  logic [31:0] temp0_q;
  logic        inv0_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      p0_q    <= data_i.neg ? (64'd0 - data_i.num) : data_i.num;
      temp0_q <= data_i.temp;
      inv0_q  <= data_i.inval;
    end
  end

  // Stage 1: P9 and P8 products.
  logic [63:0] s0;
  logic [63:0] p1_q, s1_q, m9_q, q2p_q;
  logic [31:0] temp1_q;
  logic        inv1_q;

  assign s0 = 64'($signed(p0_q) >>> 13);

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      p1_q    <= p0_q;
      s1_q    <= s0;
      m9_q    <= bptc_pkg::mul64x17(s0, {cal_i.p9[15], cal_i.p9});
      q2p_q   <= bptc_pkg::mul64x17(p0_q, {cal_i.p8[15], cal_i.p8});
      temp1_q <= temp0_q;
      inv1_q  <= inv0_q;
    end
  end

  // Stage 2: partial products of the 64 by 64 product, modulo 2^64.
  logic [63:0] ll;
  logic [63:0] ll_q, p2_q, q2p2_q;
  logic [31:0] lh_q, hl_q, temp2_q;
  logic        inv2_q;

  assign ll = m9_q[31:0] * s1_q[31:0];

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      ll_q    <= ll;
      lh_q    <= m9_q[31:0] * s1_q[63:32];
      hl_q    <= m9_q[63:32] * s1_q[31:0];
      p2_q    <= p1_q;
      q2p2_q  <= q2p_q;
      temp2_q <= temp1_q;
      inv2_q  <= inv1_q;
    end
  end

  // Stage 3: correction terms.
  logic [63:0] q1raw;
  logic [63:0] q1_q, q2_q, p3_q;
  logic [31:0] temp3_q;
  logic        inv3_q;

  assign q1raw = ll_q + {lh_q + hl_q, 32'd0};

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      q1_q    <= 64'($signed(q1raw) >>> 25);
      q2_q    <= 64'($signed(q2p2_q) >>> 19);
      p3_q    <= p2_q;
      temp3_q <= temp2_q;
      inv3_q  <= inv2_q;
    end
  end

  // Stage 4: final sum into the output register.
  logic [63:0] psum, p7x, pfin;

  assign psum = p3_q + q1_q + q2_q;
  assign p7x  = {{48{cal_i.p7[15]}}, cal_i.p7};
  assign pfin = 64'($signed(psum) >>> 8) + (p7x << 4);

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      temp_centi_o    <= $signed(temp3_q);
      press_q24_8_o   <= inv3_q ? 32'd0 : pfin[31:0];
      press_invalid_o <= inv3_q;
    end
  end

endmodule
